@@ sv/tgarle_pkg.sv @@
// Shared types and constants for the TGA RLE pixel decoder.
package tgarle_pkg;

	localparam int DIM_BITS_DEF = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int BPP_W        = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [BPP_W-1:0] BPP_RGBA  = 3'd4;
	localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;

	localparam logic [7:0] REPEAT_BIAS = 8'd127;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_EARLY_END = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] run_length;
		logic       last_run;
		status_t    status;
	} run_t;

endpackage

@@ sv/tga_rle_pixel_decoder_core.sv @@
// Top level of the TGA RLE pixel decoder: configuration, decode state, result register.
//
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   data_byte, end_of_data
// result    out        out_valid/out_stall red, green, blue, alpha, run_length, last_run, status
// config    in         cfg_we              cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; a run token appears in the cycle after the byte that completes it.
// The result register holds one token; a new request is taken when it is empty or draining.
// A write to BPP, WIDTH or HEIGHT reloads the pixel budget (width * height) in the next cycle,
// and requests stall during that cycle.
// Reset selects 3 bytes per pixel and a 1 x 1 image.
module tga_rle_pixel_decoder_core #(
	parameter int DIM_BITS = tgarle_pkg::DIM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              end_of_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        red,
	output logic [7:0]                        green,
	output logic [7:0]                        blue,
	output logic [7:0]                        alpha,
	output logic [7:0]                        run_length,
	output logic                              last_run,
	output logic [1:0]                        status,
	input  logic                              cfg_we,
	input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tgarle_pkg::*;

	localparam int PIX_BITS = 2 * DIM_BITS;

	logic [BPP_W-1:0]      bpp_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic                  pend_q;
	logic [PIX_BITS-1:0]   reload_pixels;
	logic                  accept;
	logic                  res_valid;
	run_t                  res;
	logic                  out_valid_q;
	run_t                  out_q;

	assign reload_pixels = PIX_BITS'(width_q[DIM_BITS-1:0]) * PIX_BITS'(height_q[DIM_BITS-1:0]);

	assign in_stall = pend_q | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= BPP_RESET;
			width_q  <= CFG_DATA_W'(1);
			height_q <= CFG_DATA_W'(1);
			pend_q   <= 1'b0;
		end else begin
			pend_q <= cfg_we & ((cfg_index == REG_BPP) | (cfg_index == REG_WIDTH) |
				(cfg_index == REG_HEIGHT));
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BPP: begin
						bpp_q <= cfg_data[BPP_W-1:0];
					end
					REG_WIDTH: begin
						width_q <= cfg_data;
					end
					REG_HEIGHT: begin
						height_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	tgarle_ctrl #(
		.DIM_BITS (DIM_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_data   (end_of_data),
		.rearm         (pend_q),
		.bpp4          (bpp_q == BPP_RGBA),
		.reload_pixels (reload_pixels),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = out_q.red;
	assign green      = out_q.green;
	assign blue       = out_q.blue;
	assign alpha      = out_q.alpha;
	assign run_length = out_q.run_length;
	assign last_run   = out_q.last_run;
	assign status     = out_q.status;

endmodule

@@ sv/tgarle_ctrl.sv @@
// Packet and pixel decode state with the per-byte run token logic.
module tgarle_ctrl #(
	parameter int DIM_BITS = tgarle_pkg::DIM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_data,
	input  logic                  rearm,
	input  logic                  bpp4,
	input  logic [2*DIM_BITS-1:0] reload_pixels,
	output logic                  res_valid,
	output tgarle_pkg::run_t      res
);
	import tgarle_pkg::*;

	localparam int PIX_BITS = 2 * DIM_BITS;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXEL,
		PH_DONE
	} phase_t;

	phase_t               phase_q, n_phase;
	logic [7:0]           ppl_q, n_ppl;
	logic                 repeat_q, n_repeat;
	logic [1:0]           idx_q, n_idx;
	logic [23:0]          asm_q, n_asm;
	logic [PIX_BITS-1:0]  left_q, n_left;

	logic [2:0]           bpp;
	logic [7:0]           need;
	logic [7:0]           run_raw;
	logic [7:0]           run;
	logic [PIX_BITS-1:0]  left_after;

	always_comb begin
		n_phase    = phase_q;
		n_ppl      = ppl_q;
		n_repeat   = repeat_q;
		n_idx      = idx_q;
		n_asm      = asm_q;
		n_left     = left_q;
		res        = '0;
		res_valid  = 1'b0;
		bpp        = bpp4 ? 3'd4 : 3'd3;
		need       = ppl_q;
		run_raw    = repeat_q ? ppl_q : 8'd1;
		if ({{(PIX_BITS-8){1'b0}}, run_raw} > left_q) begin
			run = left_q[7:0];
		end else begin
			run = run_raw;
		end
		left_after = left_q - {{(PIX_BITS-8){1'b0}}, run};

		unique case (phase_q)
			PH_HEADER: begin
				if (left_q == '0) begin
					res.last_run = 1'b1;
					res.status   = ST_OVERFLOW;
					res_valid    = 1'b1;
					n_phase      = PH_DONE;
				end else begin
					n_repeat = data_byte[7];
					n_ppl    = data_byte[7] ? (data_byte - REPEAT_BIAS) : (data_byte + 8'd1);
					n_idx    = 2'd0;
					n_asm    = '0;
					n_phase  = PH_PIXEL;
				end
			end
			PH_PIXEL: begin
				if (({1'b0, idx_q} + 3'd1) < bpp) begin
					unique case (idx_q)
						2'd0:    n_asm = asm_q | {16'd0, data_byte};
						2'd1:    n_asm = asm_q | {8'd0, data_byte, 8'd0};
						default: n_asm = asm_q | {data_byte, 16'd0};
					endcase
					n_idx = idx_q + 2'd1;
				end else begin
					res.red        = bpp4 ? asm_q[23:16] : data_byte;
					res.green      = asm_q[15:8];
					res.blue       = asm_q[7:0];
					res.alpha      = bpp4 ? data_byte : 8'd0;
					res.run_length = run;
					res_valid      = 1'b1;
					n_left         = left_after;
					n_idx          = 2'd0;
					n_asm          = '0;
					n_ppl          = repeat_q ? 8'd0 : ((need != 8'd0) ? need - 8'd1 : 8'd0);
					if (left_after == '0) begin
						res.last_run = 1'b1;
						res.status   = (need > run) ? ST_OVERFLOW : ST_OK;
						n_phase      = PH_DONE;
					end else begin
						n_phase = (n_ppl == 8'd0) ? PH_HEADER : PH_PIXEL;
					end
				end
			end
			default: begin
			end
		endcase

		if (end_of_data) begin
			if (res_valid) begin
				if (!res.last_run) begin
					res.last_run = 1'b1;
					res.status   = ST_EARLY_END;
				end
			end else if (n_phase != PH_DONE) begin
				res_valid    = 1'b1;
				res.last_run = 1'b1;
				res.status   = ST_EARLY_END;
			end
			n_phase  = PH_HEADER;
			n_ppl    = 8'd0;
			n_repeat = 1'b0;
			n_idx    = 2'd0;
			n_asm    = '0;
			n_left   = reload_pixels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			ppl_q    <= 8'd0;
			repeat_q <= 1'b0;
			idx_q    <= 2'd0;
			asm_q    <= '0;
			left_q   <= PIX_BITS'(1);
		end else if (rearm) begin
			phase_q  <= PH_HEADER;
			ppl_q    <= 8'd0;
			repeat_q <= 1'b0;
			idx_q    <= 2'd0;
			asm_q    <= '0;
			left_q   <= reload_pixels;
		end else if (accept) begin
			phase_q  <= n_phase;
			ppl_q    <= n_ppl;
			repeat_q <= n_repeat;
			idx_q    <= n_idx;
			asm_q    <= n_asm;
			left_q   <= n_left;
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the TGA RLE pixel decoder: random and directed byte streams against a run predictor.
`timescale 1ns / 100ps

module tb;
	import tgarle_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int HOLD_OFF_CYCLES = 80;

	typedef enum logic [1:0] {
		DEC_HEADER,
		DEC_PIXEL,
		DEC_DONE
	} dec_phase_t;

	typedef enum logic [1:0] {
		IMG_EXACT,
		IMG_OVERRUN,
		IMG_SHORT,
		IMG_NOISE
	} img_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eod;
	} byte_req_t;

	class run_scoreboard;
		logic [2:0]  bpp_reg;
		logic [15:0] width_reg;
		logic [15:0] height_reg;
		dec_phase_t  phase;
		int unsigned packet_left;
		bit          packet_repeat;
		int unsigned byte_idx;
		logic [23:0] assembly;
		int unsigned pixels_left;
		run_t        expected_q[$];
		int unsigned errors;

		function new();
			bpp_reg = BPP_RESET;
			width_reg = 16'd1;
			height_reg = 16'd1;
			errors = 0;
			restart_image();
		endfunction

		function void restart_image();
			phase = DEC_HEADER;
			packet_left = 0;
			packet_repeat = 1'b0;
			byte_idx = 0;
			assembly = '0;
			pixels_left = 32'(width_reg) * 32'(height_reg);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_BPP: bpp_reg = val[BPP_W-1:0];
				REG_WIDTH: width_reg = val;
				REG_HEIGHT: height_reg = val;
				default: return;
			endcase
			restart_image();
		endfunction

		function void note_request(logic [7:0] b, logic eod);
			run_t        r;
			bit          made;
			bit          last;
			int unsigned bytes;
			int unsigned need;
			int unsigned run_len;
			r = '0;
			made = 1'b0;
			last = 1'b0;
			bytes = (bpp_reg == BPP_RGBA) ? 4 : 3;
			case (phase)
				DEC_HEADER: begin
					if (pixels_left == 0) begin
						r.last_run = 1'b1;
						r.status = ST_OVERFLOW;
						made = 1'b1;
						last = 1'b1;
						phase = DEC_DONE;
					end else begin
						packet_repeat = b[7];
						packet_left = b[7] ? b - REPEAT_BIAS : b + 1;
						byte_idx = 0;
						assembly = '0;
						phase = DEC_PIXEL;
					end
				end
				DEC_PIXEL: begin
					if (byte_idx + 1 < bytes) begin
						assembly[8*byte_idx +: 8] = b;
						byte_idx++;
					end else begin
						r.blue = assembly[7:0];
						r.green = assembly[15:8];
						if (bytes == 4) begin
							r.red = assembly[23:16];
							r.alpha = b;
						end else begin
							r.red = b;
							r.alpha = 8'd0;
						end
						need = packet_left;
						run_len = packet_repeat ? need : 1;
						if (run_len > pixels_left)
							run_len = pixels_left;
						pixels_left -= run_len;
						byte_idx = 0;
						assembly = '0;
						packet_left = packet_repeat ? 0 : (need > 0 ? need - 1 : 0);
						r.run_length = 8'(run_len);
						made = 1'b1;
						if (pixels_left == 0) begin
							r.last_run = 1'b1;
							if (need > run_len)
								r.status = ST_OVERFLOW;
							else
								r.status = ST_OK;
							last = 1'b1;
							phase = DEC_DONE;
						end else begin
							phase = (packet_left == 0) ? DEC_HEADER : DEC_PIXEL;
						end
					end
				end
				default: ;
			endcase
			if (eod) begin
				if (made) begin
					if (!last) begin
						r.last_run = 1'b1;
						r.status = ST_EARLY_END;
					end
				end else if (phase != DEC_DONE) begin
					r = '0;
					r.last_run = 1'b1;
					r.status = ST_EARLY_END;
					made = 1'b1;
				end
				restart_image();
			end
			if (made)
				expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(run_t got);
			run_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected run token %p", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("red", want.red, got.red);
			compare_field("green", want.green, got.green);
			compare_field("blue", want.blue, got.blue);
			compare_field("alpha", want.alpha, got.alpha);
			compare_field("run_length", want.run_length, got.run_length);
			compare_field("last_run", 8'(want.last_run), 8'(got.last_run));
			compare_field("status", 8'(want.status), 8'(got.status));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte = 8'd0;
	logic                  end_of_data = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic [7:0]            alpha;
	logic [7:0]            run_length;
	logic                  last_run;
	logic [1:0]            status;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	run_scoreboard sb = new();
	int unsigned   gap_max = 4;
	int unsigned   stall_max = 4;
	bit            hold_off_req = 1'b0;
	int unsigned   idle_cycles = 0;

	tga_rle_pixel_decoder_core u_top (.*);

	always #2 clk = ~clk;

	task automatic send_request(input logic [7:0] b, input logic eod);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_data <= eod;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(b, eod);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [2:0] bpp, input logic [15:0] w, input logic [15:0] h);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_BPP;
		cfg_data <= CFG_DATA_W'(bpp);
		@(posedge clk);
		sb.set_register(REG_BPP, CFG_DATA_W'(bpp));
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		sb.set_register(REG_WIDTH, w);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		sb.set_register(REG_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	function automatic void add_packet(ref byte_req_t q[$], input logic [7:0] header,
			input int unsigned pixels, input int unsigned bytes);
		byte_req_t r;
		r.eod = 1'b0;
		r.data = header;
		q.push_back(r);
		repeat (pixels * bytes) begin
			r.data = 8'($urandom_range(0, 255));
			q.push_back(r);
		end
	endfunction

	// drain results
	initial begin
		int unsigned wait_left;
		wait_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(run_t'({red, green, blue, alpha, run_length, last_run, status}));
				wait_left = $urandom_range(0, stall_max);
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				wait_left = HOLD_OFF_CYCLES;
			end
			out_stall <= (wait_left != 0);
			if (wait_left != 0)
				wait_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int unsigned sent;
		bit          first;
		int unsigned bpp_val;
		int unsigned w;
		int unsigned h;
		int unsigned roll;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// exact fill of a 1 x 1 image at reset settings
		send_request(8'h00, 1'b0);
		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b0);
		send_request(8'h80, 1'b1);

		// clipped repeat, end on a done image, header with end of data
		configure(BPP_RGBA, 16'd2, 16'd1);
		send_request(8'hFF, 1'b0);
		send_request(8'h01, 1'b0);
		send_request(8'h02, 1'b0);
		send_request(8'h03, 1'b0);
		send_request(8'hFE, 1'b0);
		send_request(8'h55, 1'b1);
		send_request(8'h7F, 1'b1);

		// zero-size image
		configure(BPP_RGBA, 16'd0, 16'd1);
		send_request(8'h80, 1'b0);
		send_request(8'h00, 1'b1);

		// largest image, cut short on a run and inside a pixel
		configure(3'd7, 16'hFFFF, 16'hFFFF);
		send_request(8'h81, 1'b0);
		send_request(8'h10, 1'b0);
		send_request(8'h20, 1'b0);
		send_request(8'h30, 1'b1);
		send_request(8'h01, 1'b0);
		send_request(8'hAA, 1'b0);
		send_request(8'hBB, 1'b1);

		// raw packet longer than the image
		configure(3'd0, 16'd1, 16'd2);
		send_request(8'h02, 1'b0);
		repeat (6) send_request(8'($urandom_range(0, 255)), 1'b0);
		send_request(8'h00, 1'b1);

		sent = 0;
		first = 1'b1;
		while (sent < 950) begin
			roll = $urandom_range(0, 9);
			if (roll < 4)
				bpp_val = BPP_RESET;
			else if (roll < 8)
				bpp_val = BPP_RGBA;
			else
				bpp_val = $urandom_range(0, 7);
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 6);
			case ($urandom_range(0, 19))
				0: w = 16'hFFFF;
				1: h = 16'hFFFF;
				2: w = 0;
				3: h = 0;
				default: ;
			endcase
			if (first) begin
				w = $urandom_range(2, 6);
				h = $urandom_range(2, 6);
			end
			configure(3'(bpp_val), 16'(w), 16'(h));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			if (first) begin
				gap_max = 0;
				hold_off_req = 1'b1;
				first = 1'b0;
			end
			repeat ($urandom_range(1, 4)) begin : one_image
				byte_req_t   q[$];
				byte_req_t   r;
				img_kind_t   kind;
				int unsigned bytes;
				int unsigned pixels;
				int unsigned left;
				int unsigned cnt;
				int unsigned cap;

				q.delete();
				bytes = (3'(bpp_val) == BPP_RGBA) ? 4 : 3;
				pixels = 32'(w) * 32'(h);
				roll = $urandom_range(0, 19);
				if (roll < 11)
					kind = IMG_EXACT;
				else if (roll < 14)
					kind = IMG_OVERRUN;
				else if (roll < 17)
					kind = IMG_SHORT;
				else
					kind = IMG_NOISE;
				if (pixels == 0)
					kind = IMG_NOISE;
				cap = (pixels > 4096) ? 40 : 100000;
				left = pixels;
				if (kind != IMG_NOISE) begin
					while (left != 0 && q.size() < cap) begin
						if (kind == IMG_OVERRUN && left <= 120) begin
							cnt = left + $urandom_range(1, 8);
							if ($urandom_range(0, 1))
								add_packet(q, 8'(cnt + REPEAT_BIAS), 1, bytes);
							else
								add_packet(q, 8'(cnt - 1), left + 1, bytes);
							left = 0;
						end else begin
							if ($urandom_range(0, 1)) begin
								cnt = $urandom_range(1, left < 128 ? left : 128);
								add_packet(q, 8'(cnt + REPEAT_BIAS), 1, bytes);
							end else begin
								cnt = $urandom_range(1, left < 16 ? left : 16);
								add_packet(q, 8'(cnt - 1), cnt, bytes);
							end
							left -= cnt;
						end
					end
				end
				if (kind == IMG_SHORT && q.size() > 1)
					repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
				if (kind == IMG_NOISE || (kind == IMG_EXACT && $urandom_range(0, 3) == 0)) begin
					repeat ($urandom_range(1, 12)) begin
						r.data = 8'($urandom_range(0, 255));
						r.eod = ($urandom_range(0, 5) == 0);
						q.push_back(r);
					end
				end
				q[q.size() - 1].eod = 1'b1;
				foreach (q[i])
					send_request(q[i].data, q[i].eod);
				sent += q.size();
			end
		end

		settle();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/tgarle_pkg.sv
sv/tgarle_ctrl.sv
sv/tga_rle_pixel_decoder_core.sv
tb/sv/tb.sv
